@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key table assertion failed");

// Next-cycle implication, checked in reset as well.
`define TSD_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("key table assertion failed");

`endif

@@ rtl/tsd_pkg.sv @@
package tsd_pkg;

   typedef enum logic [2:0] {
      OP_INIT_STATIC = 3'd0,
      OP_CREATE      = 3'd1,
      OP_DELETE      = 3'd2,
      OP_SET         = 3'd3,
      OP_RAW_SET     = 3'd4,
      OP_GET         = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NOFREE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DONE
   } state_type;

   localparam int BITMAP_WIDTH = 32;
   localparam int BIT_SEL_WIDTH = 5;
   localparam int VALUE_WIDTH = 64;

endpackage

@@ rtl/tsd_if.sv @@
interface tsd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  thread_id;
   logic [31:0] key;
   logic [63:0] value;
   logic [63:0] destructor;
   logic        no_result_slot;

   modport source (output valid, opcode, thread_id, key, value, destructor, no_result_slot,
                   input ready);
   modport sink (input valid, opcode, thread_id, key, value, destructor, no_result_slot,
                 output ready);
endinterface

interface tsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [9:0]  key_out;
   logic [63:0] value_out;

   modport source (output valid, status, key_out, value_out, input ready);
   modport sink (input valid, status, key_out, value_out, output ready);
endinterface

@@ rtl/tsd_key_registry_table_unit.sv @@
// Thread-specific-data key table.
// The req channel carries one operation per transfer: static key init, create,
// delete, set, raw static set or get, with the calling thread, key, value and
// destructor. The rsp channel returns one result per request: status, the key
// allocated by create and the value read by get.
// Registered bits live in a 32-bit-wide bitmap memory, destructors in their own
// memory, and each key owns one row holding the values of all thread banks, so a
// delete clears every bank with a single row write.
// rsp.valid rises once a request has passed a memory read (S_READ), a
// read-modify-write step (S_EXEC) and the output register loaded in S_DONE.
// A new request is taken only in idle, not before the last result is loaded.
// Create scans the bitmap one word per read, repeating S_READ and S_EXEC for
// each full word passed. After reset a clearing pass writes every row of the
// memories, during which req.ready stays low. A new request may be taken while a
// finished result still waits in the output register; if the receiver stalls,
// that request waits in its final step until the register drains.
module tsd_key_registry_table_unit #(
   parameter int KEY_COUNT = 768,
   parameter int DYNAMIC_START = 256,
   parameter int FIRST_MANAGED_STATIC = 10,
   parameter int THREAD_COUNT = 8
) (
   input logic clock,
   input logic reset,
   tsd_req_if.sink req_chan,
   tsd_rsp_if.source rsp_chan
);
   import tsd_pkg::*;

   localparam int KW = $clog2(KEY_COUNT);
   localparam int NWORDS = (KEY_COUNT + BITMAP_WIDTH - 1) / BITMAP_WIDTH;
   localparam int WW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
   localparam int ROW_WIDTH = THREAD_COUNT * VALUE_WIDTH;
   localparam int START_WORD = DYNAMIC_START / BITMAP_WIDTH;
   localparam int LAST_WORD = (KEY_COUNT - 1) / BITMAP_WIDTH;

   logic [BITMAP_WIDTH-1:0] bitmap_mem [NWORDS];
   logic [VALUE_WIDTH-1:0]  dtor_mem [KEY_COUNT];
   logic [ROW_WIDTH-1:0]    row_mem [KEY_COUNT];

   state_type state_ff, state_in;
   logic [KW-1:0] clear_ff, clear_in;
   logic [WW-1:0] scan_ff, scan_in;
   op_type op_ff;
   logic [TW-1:0] thread_ff;
   logic [31:0] key_ff;
   logic [VALUE_WIDTH-1:0] value_ff, dtor_ff;
   logic noslot_ff;
   logic [BITMAP_WIDTH-1:0] word_rd_ff;
   logic [ROW_WIDTH-1:0] row_rd_ff;
   status_type res_status_ff, res_status_in;
   logic [9:0] res_key_ff, res_key_in;
   logic [VALUE_WIDTH-1:0] res_value_ff, res_value_in;
   logic rsp_valid_ff;
   status_type rsp_status_ff;
   logic [9:0] rsp_key_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;

   logic req_fire, rsp_load;
   logic [KW-1:0] kidx;
   logic [KW-1:0] word_full;
   logic [WW-1:0] widx, rd_widx;
   logic [BIT_SEL_WIDTH-1:0] bpos;
   logic in_table, is_dynamic, reg_bit;
   logic [VALUE_WIDTH-1:0] lane;
   logic [BITMAP_WIDTH-1:0] free_mask;
   logic free_any;
   logic [BIT_SEL_WIDTH-1:0] free_pos;
   logic [WW+BIT_SEL_WIDTH-1:0] free_key;
   logic bm_we, dt_we, row_we;
   logic [WW-1:0] bm_waddr;
   logic [BITMAP_WIDTH-1:0] bm_wdata;
   logic [KW-1:0] dt_waddr;
   logic [VALUE_WIDTH-1:0] dt_wdata;
   logic [ROW_WIDTH-1:0] row_wdata;

   function automatic logic [TW-1:0] thread_wrap(input logic [2:0] t);
      logic [6:0] v;
      v = 7'(t);
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= 32'(THREAD_COUNT)) begin
            v = v - 7'(THREAD_COUNT);
         end
      end
      return TW'(v);
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign kidx = KW'(key_ff);
   assign word_full = kidx >> BIT_SEL_WIDTH;
   assign widx = WW'(word_full);
   assign bpos = BIT_SEL_WIDTH'(kidx);
   assign in_table = key_ff < 32'(KEY_COUNT);
   assign is_dynamic = in_table && (key_ff >= 32'(DYNAMIC_START));
   assign reg_bit = word_rd_ff[bpos];
   assign lane = row_rd_ff[thread_ff*VALUE_WIDTH +: VALUE_WIDTH];
   assign rd_widx = (op_ff == OP_CREATE) ? scan_ff : widx;

   always_comb begin
      free_any = 1'b0;
      free_pos = '0;
      for (int b = 0; b < BITMAP_WIDTH; b++) begin
         free_mask[b] = !word_rd_ff[b]
            && (32'({scan_ff, BIT_SEL_WIDTH'(b)}) >= 32'(DYNAMIC_START))
            && (32'({scan_ff, BIT_SEL_WIDTH'(b)}) < 32'(KEY_COUNT));
      end
      for (int b = BITMAP_WIDTH - 1; b >= 0; b--) begin
         if (free_mask[b]) begin
            free_any = 1'b1;
            free_pos = BIT_SEL_WIDTH'(b);
         end
      end
   end
   assign free_key = {scan_ff, free_pos};

   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      scan_in = scan_ff;
      res_status_in = res_status_ff;
      res_key_in = res_key_ff;
      res_value_in = res_value_ff;
      bm_we = 1'b0;
      bm_waddr = widx;
      bm_wdata = word_rd_ff;
      dt_we = 1'b0;
      dt_waddr = kidx;
      dt_wdata = dtor_ff;
      row_we = 1'b0;
      row_wdata = row_rd_ff;
      unique case (state_ff)
         S_CLEAR: begin
            bm_we = 32'(clear_ff) < 32'(NWORDS);
            bm_waddr = WW'(clear_ff);
            bm_wdata = '0;
            dt_we = 1'b1;
            dt_waddr = clear_ff;
            dt_wdata = '0;
            row_we = 1'b1;
            row_wdata = '0;
            clear_in = clear_ff + 1'b1;
            if (32'(clear_ff) == 32'(KEY_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            scan_in = WW'(START_WORD);
            if (req_fire) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            res_status_in = STATUS_OK;
            res_key_in = '0;
            res_value_in = '0;
            unique case (op_ff)
               OP_INIT_STATIC: begin
                  if (key_ff < 32'(FIRST_MANAGED_STATIC) || key_ff >= 32'(DYNAMIC_START)
                      || !in_table) begin
                     res_status_in = STATUS_INVALID;
                  end else if (!reg_bit) begin
                     bm_we = 1'b1;
                     bm_wdata[bpos] = 1'b1;
                     dt_we = 1'b1;
                  end
               end
               OP_CREATE: begin
                  if (noslot_ff) begin
                     res_status_in = STATUS_INVALID;
                  end else if (DYNAMIC_START >= KEY_COUNT) begin
                     res_status_in = STATUS_NOFREE;
                  end else if (free_any) begin
                     bm_we = 1'b1;
                     bm_waddr = scan_ff;
                     bm_wdata[free_pos] = 1'b1;
                     dt_we = 1'b1;
                     dt_waddr = KW'(free_key);
                     res_key_in = 10'(free_key);
                  end else if (32'(scan_ff) >= 32'(LAST_WORD)) begin
                     res_status_in = STATUS_NOFREE;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
               OP_DELETE: begin
                  if (!is_dynamic || !reg_bit) begin
                     res_status_in = STATUS_INVALID;
                  end else begin
                     bm_we = 1'b1;
                     bm_wdata[bpos] = 1'b0;
                     dt_we = 1'b1;
                     dt_wdata = '0;
                     row_we = 1'b1;
                     row_wdata = '0;
                  end
               end
               OP_SET: begin
                  if (key_ff < 32'(FIRST_MANAGED_STATIC) || !in_table
                      || (is_dynamic && !reg_bit)) begin
                     res_status_in = STATUS_INVALID;
                  end else begin
                     if (!reg_bit) begin
                        bm_we = 1'b1;
                        bm_wdata[bpos] = 1'b1;
                        dt_we = 1'b1;
                        dt_wdata = '0;
                     end
                     row_we = 1'b1;
                     row_wdata[thread_ff*VALUE_WIDTH +: VALUE_WIDTH] = value_ff;
                  end
               end
               OP_RAW_SET: begin
                  if (key_ff >= 32'(DYNAMIC_START) || !in_table) begin
                     res_status_in = STATUS_INVALID;
                  end else begin
                     row_we = 1'b1;
                     row_wdata[thread_ff*VALUE_WIDTH +: VALUE_WIDTH] = value_ff;
                  end
               end
               OP_GET: begin
                  res_value_in = in_table ? lane : '0;
               end
               default: begin
                  res_status_in = STATUS_INVALID;
               end
            endcase
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clear_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      res_status_ff <= res_status_in;
      res_key_ff <= res_key_in;
      res_value_ff <= res_value_in;
      if (req_fire) begin
         op_ff <= op_type'(req_chan.opcode);
         thread_ff <= thread_wrap(req_chan.thread_id);
         key_ff <= req_chan.key;
         value_ff <= req_chan.value;
         dtor_ff <= req_chan.destructor;
         noslot_ff <= req_chan.no_result_slot;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff <= res_key_ff;
         rsp_value_ff <= res_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         word_rd_ff <= bitmap_mem[rd_widx];
         row_rd_ff <= row_mem[kidx];
      end
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      if (dt_we) begin
         dtor_mem[dt_waddr] <= dt_wdata;
      end
      if (row_we) begin
         row_mem[(state_ff == S_CLEAR) ? clear_ff : kidx] <= row_wdata;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.key_out = rsp_key_ff;
   assign rsp_chan.value_out = rsp_value_ff;

`include "assert_macros.svh"

   `TSD_ASSERT_NEXT(a_clear_after_reset, clock, reset, !req_chan.ready)
   `TSD_ASSERT_IMP(a_create_key_range, clock, reset,
      state_ff == S_EXEC && op_ff == OP_CREATE && dt_we,
      32'(free_key) >= 32'(DYNAMIC_START) && 32'(free_key) < 32'(KEY_COUNT))
   `TSD_ASSERT_IMP(a_no_write_in_idle, clock, reset,
      state_ff == S_IDLE || state_ff == S_DONE, !bm_we && !dt_we && !row_we)

endmodule
